[rtl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Shared codes, control/status bundles and saturation helper for the
// postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  // Operator codes carried in the input tuser
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Status codes carried in the output tuser
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       cap_tok;   // capture the accepted token
    logic       push;      // write operand at stack top, count up
    logic       rd_en;     // read the stack memory
    logic       rd_next;   // read address count-2 instead of count-1
    logic       ld_b;      // right operand from read data
    logic       ld_a_pop;  // left operand from read data, count down by two
    logic       calc;      // register add, subtract or product
    logic       div_start; // launch the divider
    logic       wb;        // write the operator result, count up
    logic       wb_div;    // the written result comes from the divider
    logic       set_err;   // record an error if none is pending
    logic [1:0] err_code;
    logic       out_load;  // load the output register
    logic       clear;     // empty the stack and clear the error
  } pse_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic       action;
    logic [1:0] op;
    logic       last;
    logic       err_set;
    logic       lt2;
    logic       full;
    logic       empty;
    logic       b_zero;
    logic       div_done;
    logic       out_free;
  } pse_sts_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] max_v;
    logic signed [63:0] min_v;
    max_v = 64'sh0000_0000_7FFF_FFFF;
    min_v = -64'sh0000_0000_8000_0000;
    if (v > max_v) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < min_v) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

[rtl/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates a postfix expression of Q16.16 operands and operators over a
// value stack, one token per transaction, with saturating arithmetic.
//
//   Channel  Dir  Ports                    Content
//   s_axis   in   tdata[31:0]              operand_value
//                 tuser[2:0]               action, operator_code
//                 tlast                    last_token
//   m_axis   out  tdata[31:0]              result_value
//                 tuser[1:0]               status
//
// A push passes through decode and finish before the next token is accepted; add,
// subtract and multiply also read the two operands in turn through the single read
// port, then execute and write back. Divide waits on the 32-step radix-2 divider;
// a zero divisor skips the divider; a last token waits for a free output register.
// Reset empties the stack and clears the error; memory contents stay undefined.
// A stalled output holds its result; the next token is accepted while it waits.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
  input  logic [2:0]  s_axis_tuser,   // [0] action, [2:1] operator_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  pse_pkg::pse_cmd_t cmd;
  pse_pkg::pse_sts_t sts;

  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pse_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .tok_data_i  (s_axis_tdata),
    .tok_user_i  (s_axis_tuser),
    .tok_last_i  (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

[rtl/pse_div.sv]
// ----------------------------------------------------------------------------
// pse_div
// Radix-2 restoring divider for Q16.16: (a * 65536) / b, truncated toward
// zero and saturated. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] sh_q, sh_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        ovf_q, ovf_d;
  logic [32:0] trial;
  logic [32:0] diff;

  // Operand magnitudes; the most negative value maps to 2^31
  assign mag_a = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign mag_b = b_i[31] ? (~b_i + 32'd1) : b_i;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, sh_q[31]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      rem_d  = {16'd0, mag_a[31:16]};
      sh_d   = {mag_a[15:0], 16'd0};
      den_d  = mag_b;
      neg_d  = a_i[31] ^ b_i[31];
      // Quotient of 2^32 or more cannot fit: flag it up front
      ovf_d  = ({16'd0, mag_a} >= {mag_b, 16'd0});
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        sh_d  = {sh_q[30:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        sh_d  = {sh_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
    neg_q <= neg_d;
    ovf_q <= ovf_d;
  end

  // Apply the sign and clamp
  always_comb begin
    if (ovf_q) begin
      quot_o = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_q) begin
      quot_o = (sh_q > 32'h8000_0000) ? 32'h8000_0000 : (~sh_q + 32'd1);
    end else begin
      quot_o = sh_q[31] ? 32'h7FFF_FFFF : sh_q;
    end
  end

  assign done_o = done_q;

endmodule

[rtl/pse_dpath.sv]
// ----------------------------------------------------------------------------
// pse_dpath
// Token register, value stack memory, count and error registers, ALU,
// divider and output register.
// ----------------------------------------------------------------------------
module pse_dpath #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pse_pkg::pse_cmd_t cmd_i,
  output pse_pkg::pse_sts_t sts_o,
  input  logic [31:0]       tok_data_i,
  input  logic [2:0]        tok_user_i,
  input  logic              tok_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       out_data_o,
  output logic [1:0]        out_user_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  logic [31:0]       opnd_q;
  logic              act_q;
  logic [1:0]        op_q;
  logic              last_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        err_q, err_d;
  logic [31:0]       mem [STACK_DEPTH];
  logic [31:0]       rd_q;
  logic [CntW-1:0]   rd_cnt;
  logic [31:0]       a_q;
  logic [31:0]       b_q;
  logic signed [63:0] alu_q;
  logic signed [63:0] alu_d;
  logic signed [63:0] alu_adj;
  logic [31:0]       alu_res;
  logic [31:0]       div_quot;
  logic              div_done;
  logic [31:0]       wr_data;
  logic              wr_en;
  logic              out_valid_q;
  logic [31:0]       out_data_q;
  logic [1:0]        out_user_q;

  // Capture the accepted token
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_tok) begin
      opnd_q <= tok_data_i;
      act_q  <= tok_user_i[0];
      op_q   <= tok_user_i[2:1];
      last_q <= tok_last_i;
    end
  end

  // Stack count and sticky error
  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
      err_d = pse_pkg::ST_OK;
    end else begin
      if (cmd_i.push || cmd_i.wb) begin
        cnt_d = cnt_q + CntW'(1);
      end else if (cmd_i.ld_a_pop) begin
        cnt_d = cnt_q - CntW'(2);
      end
      if (cmd_i.set_err && (err_q == pse_pkg::ST_OK)) begin
        err_d = cmd_i.err_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= pse_pkg::ST_OK;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  // Stack memory: one write port at the count, one registered read port
  assign wr_en   = cmd_i.push || cmd_i.wb;
  assign wr_data = cmd_i.push ? opnd_q : (cmd_i.wb_div ? div_quot : alu_res);
  assign rd_cnt  = cmd_i.rd_next ? (cnt_q - CntW'(2)) : (cnt_q - CntW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AddrW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_cnt[AddrW-1:0]];
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_b) begin
      b_q <= rd_q;
    end
    if (cmd_i.ld_a_pop) begin
      a_q <= rd_q;
    end
  end

  // Add, subtract or full product, registered before the clamp
  always_comb begin
    unique case (op_q)
      pse_pkg::OP_ADD: alu_d = 64'(signed'(a_q)) + 64'(signed'(b_q));
      pse_pkg::OP_SUB: alu_d = 64'(signed'(a_q)) - 64'(signed'(b_q));
      default:         alu_d = 64'(signed'(a_q)) * 64'(signed'(b_q));
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      alu_q <= alu_d;
    end
  end

  // Product drops the fraction with rounding toward minus infinity
  assign alu_adj = (op_q == pse_pkg::OP_MUL) ? (alu_q >>> pse_pkg::FracW) : alu_q;
  assign alu_res = pse_pkg::sat32(alu_adj);

  pse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (a_q),
    .b_i     (b_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Output register: holds a result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (err_q != pse_pkg::ST_OK) begin
        out_data_q <= '0;
        out_user_q <= err_q;
      end else if (cnt_q == '0) begin
        out_data_q <= '0;
        out_user_q <= pse_pkg::ST_UNDERFLOW;
      end else begin
        out_data_q <= rd_q;
        out_user_q <= pse_pkg::ST_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // Status toward the controller
  assign sts_o.action   = act_q;
  assign sts_o.op       = op_q;
  assign sts_o.last     = last_q;
  assign sts_o.err_set  = (err_q != pse_pkg::ST_OK);
  assign sts_o.lt2      = (cnt_q < CntW'(2));
  assign sts_o.full     = (cnt_q == CntW'(STACK_DEPTH));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.b_zero   = (b_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

[rtl/pse_ctrl.sv]
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer for one token: decode, stack reads, execute, write back and
// result delivery.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pse_pkg::pse_sts_t sts_i,
  output pse_pkg::pse_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RD_B   = 4'd2;
  localparam logic [3:0] S_RD_A   = 4'd3;
  localparam logic [3:0] S_EXEC   = 4'd4;
  localparam logic [3:0] S_DIVW   = 4'd5;
  localparam logic [3:0] S_WB     = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_tok = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FIN;
        if (!sts_i.err_set) begin
          if (!sts_i.action) begin
            if (sts_i.full) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = pse_pkg::ST_OVERFLOW;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else if (sts_i.lt2) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pse_pkg::ST_UNDERFLOW;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_RD_B;
          end
        end
      end
      S_RD_B: begin
        cmd_o.ld_b    = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = S_RD_A;
      end
      S_RD_A: begin
        cmd_o.ld_a_pop = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.op == pse_pkg::OP_DIV) begin
          if (sts_i.b_zero) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pse_pkg::ST_DIV_ZERO;
            state_d        = S_FIN;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIVW;
          end
        end else begin
          cmd_o.calc = 1'b1;
          state_d    = S_WB;
        end
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb     = 1'b1;
        cmd_o.wb_div = (sts_i.op == pse_pkg::OP_DIV);
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else begin
          // Fetch the stack top for the result
          cmd_o.rd_en = !sts_i.empty;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
